// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

    localparam int FIELD_W      = 32;
    localparam int MOD_BITS_DEF = 32;
    localparam int EXP_BITS_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT_REDUCE,
        ST_CHECK,
        ST_WAIT_ACC,
        ST_WAIT_SQUARE,
        ST_FINISH
    } mexp_state_t;

    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_ACC,
        MUL_SQUARE
    } mexp_mul_op_t;

    typedef struct packed {
        logic         load;
        logic         mul_start;
        mexp_mul_op_t mul_op;
        logic         wr_acc;
        logic         wr_base;
        logic         exp_shift;
        logic         out_load;
    } mexp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
    } mexp_status_t;

endpackage

// ===== hdl/mexp_dp.sv =====
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_cmd_t          cmd,
    output mexp_status_t       status,
    input  logic [FIELD_W-1:0] base_value,
    input  logic [FIELD_W-1:0] exponent_value,
    input  logic [FIELD_W-1:0] modulus_value,
    output logic [FIELD_W-1:0] power_result,
    output logic               modulus_error
);

    localparam int MW = MOD_BITS;
    localparam int EW = EXP_BITS;
    localparam int XW = (MW > FIELD_W) ? MW : FIELD_W;
    localparam int YW = (EW > FIELD_W) ? EW : FIELD_W;
    localparam int CW = $clog2(MW + 1);

    logic [XW-1:0]   base_x;
    logic [XW-1:0]   mod_x;
    logic [YW-1:0]   exp_x;
    logic [XW-1:0]   res_x;
    logic [MW-1:0]   base_in;
    logic [MW-1:0]   mod_in;
    logic [EW-1:0]   exp_in;

    logic [MW-1:0]   mod_reg;
    logic [MW-1:0]   base_reg;
    logic [MW-1:0]   acc_reg;
    logic [EW-1:0]   exp_reg;
    logic            err_reg;
    logic [MW-1:0]   mul_a_reg;
    logic [MW-1:0]   mul_b_reg;
    logic [MW-1:0]   prod_reg;
    logic [MW-1:0]   prod_next;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic [FIELD_W-1:0] power_result_reg;
    logic            modulus_error_reg;

    logic [MW-1:0]   one_mod;
    logic [MW-1:0]   op_a;
    logic [MW-1:0]   op_b;
    logic [MW+1:0]   sum_t;
    logic [MW+1:0]   one_m;
    logic [MW+1:0]   two_m;

    assign base_x  = XW'(base_value);
    assign mod_x   = XW'(modulus_value);
    assign exp_x   = YW'(exponent_value);
    assign base_in = base_x[MW-1:0];
    assign mod_in  = mod_x[MW-1:0];
    assign exp_in  = exp_x[EW-1:0];
    assign res_x   = XW'(acc_reg);

    assign one_mod = (mod_reg == MW'(1)) ? '0 : MW'(1);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_REDUCE:
            begin
                op_a = one_mod;
                op_b = base_reg;
            end
            MUL_ACC:
            begin
                op_a = acc_reg;
                op_b = base_reg;
            end
            MUL_SQUARE:
            begin
                op_a = base_reg;
                op_b = base_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // double, add the operand on a set bit, reduce below the modulus
    always_comb
    begin
        one_m = {2'b00, mod_reg};
        two_m = {1'b0, mod_reg, 1'b0};
        sum_t = {1'b0, prod_reg, 1'b0}
              + (mul_b_reg[MW-1] ? {2'b00, mul_a_reg} : '0);
        if (sum_t >= two_m)
        begin
            sum_t = sum_t - two_m;
        end
        else if (sum_t >= one_m)
        begin
            sum_t = sum_t - one_m;
        end
        prod_next = sum_t[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.mul_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(MW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_a_reg <= op_a;
            mul_b_reg <= op_b;
            prod_reg  <= '0;
        end
        else if (busy_reg)
        begin
            mul_b_reg <= {mul_b_reg[MW-2:0], 1'b0};
            prod_reg  <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_reg  <= mod_in;
            base_reg <= base_in;
            exp_reg  <= exp_in;
            err_reg  <= (mod_in == '0);
            if (mod_in == '0)
            begin
                acc_reg <= '0;
            end
            else if ((exp_in == '0) || (mod_in != MW'(1)))
            begin
                acc_reg <= MW'(1);
            end
            else
            begin
                acc_reg <= '0;
            end
        end
        else
        begin
            if (cmd.wr_acc)
            begin
                acc_reg <= prod_reg;
            end
            if (cmd.wr_base)
            begin
                base_reg <= prod_reg;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            power_result_reg  <= res_x[FIELD_W-1:0];
            modulus_error_reg <= err_reg;
        end
    end

    assign power_result  = power_result_reg;
    assign modulus_error = modulus_error_reg;

    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mul_busy = busy_reg;

`ifndef SYNTHESIS
    a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (prod_reg < mod_reg))
        else $error("partial product not reduced below modulus");

    a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_base |=> (base_reg < mod_reg))
        else $error("base power not reduced below modulus");
`endif

endmodule

// ===== hdl/mexp_ctrl.sv =====
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output mexp_cmd_t    cmd,
    input  mexp_status_t status
);

    mexp_state_t state_reg;
    mexp_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_REDUCE;
        in_stall   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.mod_zero || status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_REDUCE;
                    state_next    = ST_WAIT_REDUCE;
                end
            end
            ST_WAIT_REDUCE:
            begin
                if (!status.mul_busy)
                begin
                    cmd.wr_base = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_ACC;
                    state_next    = ST_WAIT_ACC;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SQUARE;
                    state_next    = ST_WAIT_SQUARE;
                end
            end
            ST_WAIT_ACC:
            begin
                if (!status.mul_busy)
                begin
                    cmd.wr_acc    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SQUARE;
                    state_next    = ST_WAIT_SQUARE;
                end
            end
            ST_WAIT_SQUARE:
            begin
                if (!status.mul_busy)
                begin
                    cmd.wr_base   = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !status.mul_busy)
        else $error("multiply started while multiplier busy");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded but not presented");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_START))
        else $error("accepted request did not start work");
`endif

endmodule

// ===== hdl/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: power_result = base_value ** exponent_value mod modulus_value.
// Request channel: in_valid / in_stall with base_value, exponent_value, modulus_value.
// A request is taken when in_valid is high and in_stall is low; one request is worked on
// at a time, and in_stall stays high until its result has moved into the output register.
// Result channel: out_valid / out_stall with power_result and modulus_error.
// A zero modulus gives modulus_error = 1 and power_result = 0; a zero exponent gives 1.
// The exponent is scanned from its low bit with a bit-serial modular multiplier that takes
// one multiplier bit per cycle. The base is first reduced below the modulus; then, for each
// exponent bit up to the highest set bit, a set bit multiplies the accumulator by the base
// power before the base power is squared, and a clear bit only squares it. A zero modulus
// or zero exponent skips the multiplier and goes straight to the result.
// The next request is taken while a result waits in the output register.
// When out_stall is high the result holds in the output register; a finished result
// behind it waits in the datapath and the request side stays stalled.
// Reset clears the controller and drops out_valid; no request is in flight after reset.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FIELD_W-1:0] base_value,
    input  logic [FIELD_W-1:0] exponent_value,
    input  logic [FIELD_W-1:0] modulus_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] power_result,
    output logic               modulus_error
);

    mexp_cmd_t    cmd;
    mexp_status_t status;

    mexp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mexp_dp #(
        .MOD_BITS (MOD_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .power_result   (power_result),
        .modulus_error  (modulus_error)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_COUNT  = 252;
    localparam int PHASE_SPAN    = 90;
    localparam int DRAIN_CYCLES  = 64;

    typedef struct {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] expo;
        logic [FIELD_W-1:0] modulus;
    } power_request_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power;
        logic               err;
    } power_expect_t;

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [FIELD_W-1:0] base_value     = '0;
    logic [FIELD_W-1:0] exponent_value = '0;
    logic [FIELD_W-1:0] modulus_value  = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [FIELD_W-1:0] power_result;
    logic               modulus_error;

    power_request_t request_q[$];
    power_expect_t  power_q[$];
    bit             request_held   = 1'b0;
    int             issued_count   = 0;
    int             mismatch_count = 0;
    int             cycle_count    = 0;

    modular_exponentiation_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .power_result   (power_result),
        .modulus_error  (modulus_error)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic power_expect_t predict_power(logic [FIELD_W-1:0] b,
                                                    logic [FIELD_W-1:0] e,
                                                    logic [FIELD_W-1:0] m);
        power_expect_t res;
        bit [63:0]     acc;
        bit [63:0]     pw;
        bit [63:0]     md;
        res.power = '0;
        res.err   = 1'b0;
        if (m == '0)
        begin
            res.err = 1'b1;
        end
        else if (e == '0)
        begin
            res.power = 1;
        end
        else
        begin
            md  = {32'd0, m};
            pw  = {32'd0, b} % md;
            acc = 64'd1 % md;
            for (int i = 0; i < FIELD_W; i++)
            begin
                if (e[i])
                    acc = (acc * pw) % md;
                pw = (pw * pw) % md;
            end
            res.power = acc[FIELD_W-1:0];
        end
        return res;
    endfunction

    function automatic int sender_idle_pct(int phase);
        return (phase == 0) ? 30 : (phase == 1) ? 50 : 0;
    endfunction

    function automatic int receiver_stall_pct(int phase);
        return (phase == 0) ? 50 : (phase == 1) ? 30 : 0;
    endfunction

    function automatic int idle_phase(int issued);
        return (issued < PHASE_SPAN) ? 0 : (issued < 2 * PHASE_SPAN) ? 1 : 2;
    endfunction

    task automatic add_request(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
                               logic [FIELD_W-1:0] m);
        power_request_t req;
        req.base    = b;
        req.expo    = e;
        req.modulus = m;
        request_q.push_back(req);
    endtask

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : drive_proc
        bit             launch;
        power_request_t next_req;
        launch = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                power_q.push_back(predict_power(base_value, exponent_value, modulus_value));
                request_held = 1'b0;
            end
            if (!request_held && request_q.size() != 0
                && $urandom_range(0, 99) >= sender_idle_pct(idle_phase(issued_count)))
            begin
                next_req     = request_q.pop_front();
                launch       = 1'b1;
                request_held = 1'b1;
                issued_count++;
            end
        end
        in_valid <= request_held;
        if (launch)
        begin
            base_value     <= next_req.base;
            exponent_value <= next_req.expo;
            modulus_value  <= next_req.modulus;
        end
    end

    always @(posedge clk)
    begin : check_proc
        power_expect_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (power_q.size() == 0)
            begin
                report_mismatch("result with no request", power_result, '0);
            end
            else
            begin
                want = power_q.pop_front();
                if (power_result !== want.power)
                    report_mismatch("power_result", power_result, want.power);
                if (modulus_error !== want.err)
                    report_mismatch("modulus_error", FIELD_W'(modulus_error),
                                    FIELD_W'(want.err));
            end
        end
        out_stall <= rst_n
                     && ($urandom_range(0, 99) < receiver_stall_pct(idle_phase(issued_count)));
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int                 kind;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] m;

        // zero modulus, zero exponent, modulus of one, operand extremes
        add_request(32'd5, 32'd0, 32'd0);
        add_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
        add_request(32'd7, 32'd0, 32'd1);
        add_request(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
        add_request(32'd7, 32'd3, 32'd1);
        add_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
        add_request(32'd0, 32'd5, 32'd13);
        add_request(32'd0, 32'd0, 32'd13);
        add_request(32'd1, 32'hFFFFFFFF, 32'd97);
        add_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFB);
        add_request(32'd12345, 32'd1, 32'd100);
        add_request(32'd3, 32'd2, 32'd2);
        add_request(32'hDEADBEEF, 32'h80000000, 32'h7FFFFFFF);
        add_request(32'h80000000, 32'h55555555, 32'hAAAAAAAB);
        add_request(32'h55555555, 32'hAAAAAAAA, 32'h80000001);
        add_request(32'd2, 32'd31, 32'hFFFFFFFF);
        add_request(32'd2, 32'd32, 32'hFFFFFFFF);
        add_request(32'd4294967291, 32'd4294967290, 32'd4294967291);

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            kind = $urandom_range(0, 9);
            b = $urandom;
            e = $urandom;
            m = $urandom;
            case (kind)
                4, 5: e = e >> $urandom_range(0, 31);
                6:    m = $urandom_range(1, 16);
                7:    m = 32'hFFFFFFFF - $urandom_range(0, 255);
                8:
                begin
                    if ($urandom_range(0, 1))
                        m = '0;
                    else
                        e = '0;
                end
                9:
                begin
                    case ($urandom_range(0, 3))
                        0:       m = 32'd1;
                        1:       e = 32'd1;
                        2:       b = '0;
                        default: b = 32'd1;
                    endcase
                end
                default: ;
            endcase
            add_request(b, e, m);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || request_held || power_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (power_q.size() != 0)
            report_mismatch("requests left without result", power_q.size(), '0);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mexp_pkg.sv
hdl/mexp_dp.sv
hdl/mexp_ctrl.sv
hdl/modular_exponentiation_unit.sv
bench/tb_top.sv
